### hdl/free_list_block_allocator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the free list block allocator
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition a implies condition b in the same cycle.
`define FLBA_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Condition a implies condition b in the next cycle.
`define FLBA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define FLBA_ASSERT_IMPLY(label, clk, rst, a, b)
`define FLBA_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

### hdl/flba_pkg.sv
// ---------------------------------------------------------------------------
// flba_pkg
// Codes shared by the free list block allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package flba_pkg;

   // request functions
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;

   // result status
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // fit modes
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_NEXT  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FIT_MODE    = 2'd0;
   localparam logic [1:0] CSR_HEAP_BASE   = 2'd1;
   localparam logic [1:0] CSR_HEAP_LENGTH = 2'd2;

endpackage

### hdl/free_list_block_allocator.sv
// ---------------------------------------------------------------------------
// free_list_block_allocator
// Free range table with first, best and next fit allocation and coalescing.
// ---------------------------------------------------------------------------
// One item is worked on at a time. The free table lives in a single memory
// with one read and one write port: a scan reads one entry a cycle and stops
// early on a hit, and a sorted insert, a merge with both neighbors or an
// exact-fit removal then moves each entry behind the touched place, one per
// cycle. Zero-length and unknown requests, allocations on an empty table and
// an init of an empty range skip the scan; an init that loads a range writes
// a single entry. The next item is taken while a result still waits on rsp.
`timescale 1ns / 1ps

`include "free_list_block_allocator_defines.svh"

module free_list_block_allocator #(
   parameter int FREE_ENTRIES = 64,
   parameter int ADDR_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_block_start,
   input  logic [31:0] req_block_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_start,
   output logic [31:0] rsp_granted_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = ADDR_BITS;
   localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
   localparam int CW = $clog2(FREE_ENTRIES + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(FREE_ENTRIES);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_SCAN, ST_DECIDE, ST_FIX, ST_SHIFT, ST_DONE
   } state_type;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] s_ff, s_in, len_ff, len_in;
   logic [1:0]    mode_ff, mode_in;
   logic [31:0]   base_ff, base_in, hlen_ff, hlen_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] cursor_ff, cursor_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in, chk_idx_ff, chk_idx_in;
   logic [CW-1:0] n_iss_ff, n_iss_in;
   logic          chk_v_ff, chk_v_in;
   logic          hit_ff, hit_in, found_ff, found_in;
   logic [CW-1:0] pick_ff, pick_in;
   logic [AW-1:0] pick_st_ff, pick_st_in, pick_ln_ff, pick_ln_in;
   logic          prev_v_ff, prev_v_in, next_v_ff, next_v_in;
   logic [AW-1:0] prev_st_ff, prev_st_in, prev_ln_ff, prev_ln_in;
   logic [AW-1:0] next_st_ff, next_st_in, next_ln_ff, next_ln_in;
   logic          fw_pend_ff, fw_pend_in;
   logic [IW-1:0] fw_idx_ff, fw_idx_in;
   logic [AW-1:0] fw_st_ff, fw_st_in, fw_ln_ff, fw_ln_in;
   logic          sh_pend_ff, sh_pend_in, sh_up_ff, sh_up_in;
   logic [IW-1:0] sh_rd_ff, sh_rd_in, wr_idx_ff, wr_idx_in;
   logic [CW-1:0] sh_left_ff, sh_left_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [AW-1:0] res_gs_ff, res_gs_in, res_gl_ff, res_gl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_gs_ff, rsp_gs_in, rsp_gl_ff, rsp_gl_in;

   // memory ports
   logic [2*AW-1:0] mem_q [FREE_ENTRIES];
   logic [2*AW-1:0] rdata_ff;
   logic [IW-1:0]   rd_addr, wr_addr;
   logic [2*AW-1:0] wr_data;
   logic            wr_en;

   // width adapters between 32-bit ports and address width
   logic [AW+31:0] bs_wide, bl_wide, hb_wide, hl_wide, gs_wide, gl_wide;
   logic [AW-1:0]  e_st, e_ln, hb_a, hl_a;
   logic [CW-1:0]  chk_next, rd_next, cnt_less;
   logic           pv, nv;

   assign bs_wide = {{AW{1'b0}}, req_block_start};
   assign bl_wide = {{AW{1'b0}}, req_block_length};
   assign hb_wide = {{AW{1'b0}}, base_ff};
   assign hl_wide = {{AW{1'b0}}, hlen_ff};
   assign hb_a    = hb_wide[AW-1:0];
   assign hl_a    = hl_wide[AW-1:0];
   assign gs_wide = {32'b0, res_gs_ff};
   assign gl_wide = {32'b0, res_gl_ff};

   assign e_st     = rdata_ff[2*AW-1:AW];
   assign e_ln     = rdata_ff[AW-1:0];
   assign chk_next = CW'(chk_idx_ff) + CNT_ONE;
   assign rd_next  = CW'(rd_idx_ff) + CNT_ONE;
   assign cnt_less = count_ff - CNT_ONE;
   assign pv = prev_v_ff && ((prev_st_ff + prev_ln_ff) == s_ff);
   assign nv = next_v_ff && ((s_ff + len_ff) == next_st_ff);

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_start  = rsp_gs_ff;
   assign rsp_granted_length = rsp_gl_ff;

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;       op_in = op_ff;       s_in = s_ff;   len_in = len_ff;
      mode_in = mode_ff;         base_in = base_ff;   hlen_in = hlen_ff;
      count_in = count_ff;       cursor_in = cursor_ff;
      rd_idx_in = rd_idx_ff;     chk_idx_in = chk_idx_ff;
      n_iss_in = n_iss_ff;       chk_v_in = 1'b0;
      hit_in = hit_ff;           found_in = found_ff;  pick_in = pick_ff;
      pick_st_in = pick_st_ff;   pick_ln_in = pick_ln_ff;
      prev_v_in = prev_v_ff;     prev_st_in = prev_st_ff; prev_ln_in = prev_ln_ff;
      next_v_in = next_v_ff;     next_st_in = next_st_ff; next_ln_in = next_ln_ff;
      fw_pend_in = fw_pend_ff;   fw_idx_in = fw_idx_ff;
      fw_st_in = fw_st_ff;       fw_ln_in = fw_ln_ff;
      sh_pend_in = sh_pend_ff;   sh_up_in = sh_up_ff;  sh_rd_in = sh_rd_ff;
      sh_left_in = sh_left_ff;   wr_pend_in = 1'b0;    wr_idx_in = wr_idx_ff;
      res_status_in = res_status_ff; res_gs_in = res_gs_ff; res_gl_in = res_gl_ff;
      rsp_valid_in = rsp_valid_ff; rsp_status_in = rsp_status_ff;
      rsp_gs_in = rsp_gs_ff;     rsp_gl_in = rsp_gl_ff;
      rd_addr = rd_idx_ff;
      wr_en = 1'b0;  wr_addr = fw_idx_ff;  wr_data = {fw_st_ff, fw_ln_ff};

      // drop a taken result
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            flba_pkg::CSR_FIT_MODE:    mode_in = csr_wdata[1:0];
            flba_pkg::CSR_HEAP_BASE:   base_in = csr_wdata;
            flba_pkg::CSR_HEAP_LENGTH: hlen_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_func;
               s_in     = bs_wide[AW-1:0];
               len_in   = bl_wide[AW-1:0];
               state_in = ST_START;
            end
         end

         // classify the item and set up the scan
         ST_START: begin
            res_status_in = flba_pkg::STAT_DONE;
            res_gs_in = '0;  res_gl_in = '0;
            hit_in = 1'b0;   found_in = 1'b0;  pick_in = '0;
            prev_v_in = 1'b0; next_v_in = 1'b0;
            fw_pend_in = 1'b0; sh_pend_in = 1'b0;
            n_iss_in = '0;   rd_idx_in = '0;
            state_in = ST_DONE;
            unique case (op_ff)
               flba_pkg::FUNC_ALLOC: begin
                  if (len_ff == '0 || count_ff == '0) begin
                     res_status_in = flba_pkg::STAT_NOFIT;
                  end else begin
                     if (mode_ff == flba_pkg::FIT_NEXT && CW'(cursor_ff) < count_ff) begin
                        rd_idx_in = cursor_ff;
                     end
                     state_in = ST_SCAN;
                  end
               end
               flba_pkg::FUNC_FREE: begin
                  if (len_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               flba_pkg::FUNC_INIT: begin
                  cursor_in  = '0;
                  fw_idx_in  = '0;
                  fw_st_in   = hb_a;
                  fw_ln_in   = hl_a;
                  fw_pend_in = (hl_a != '0);
                  count_in   = (hl_a != '0) ? CNT_ONE : '0;
                  if (hl_a != '0) begin
                     state_in = ST_FIX;
                  end
               end
               default: ;
            endcase
         end

         // one read issued and one entry checked per cycle
         ST_SCAN: begin
            rd_addr = rd_idx_ff;
            if (n_iss_ff < count_ff) begin
               chk_v_in   = 1'b1;
               chk_idx_in = rd_idx_ff;
               n_iss_in   = n_iss_ff + CNT_ONE;
               rd_idx_in  = (rd_next == count_ff) ? '0 : rd_next[IW-1:0];
            end
            if (chk_v_ff) begin
               if (op_ff == flba_pkg::FUNC_FREE) begin
                  if (e_st >= s_ff) begin
                     hit_in = 1'b1;  pick_in = CW'(chk_idx_ff);
                     next_v_in = 1'b1; next_st_in = e_st; next_ln_in = e_ln;
                  end else begin
                     prev_v_in = 1'b1; prev_st_in = e_st; prev_ln_in = e_ln;
                     pick_in = chk_next;
                  end
               end else if (mode_ff == flba_pkg::FIT_BEST) begin
                  if (e_ln == len_ff) begin
                     hit_in = 1'b1;  pick_in = CW'(chk_idx_ff);
                     pick_st_in = e_st; pick_ln_in = e_ln;
                  end else if (e_ln > len_ff && (!found_ff || e_ln < pick_ln_ff)) begin
                     found_in = 1'b1; pick_in = CW'(chk_idx_ff);
                     pick_st_in = e_st; pick_ln_in = e_ln;
                  end
               end else if (e_ln >= len_ff) begin
                  hit_in = 1'b1;  pick_in = CW'(chk_idx_ff);
                  pick_st_in = e_st; pick_ln_in = e_ln;
               end
            end
            if (hit_in || (!chk_v_ff && n_iss_ff == count_ff)) begin
               chk_v_in = 1'b0;
               state_in = ST_DECIDE;
            end
         end

         // choose the table update
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (op_ff == flba_pkg::FUNC_ALLOC) begin
               if (!(hit_ff || found_ff)) begin
                  res_status_in = flba_pkg::STAT_NOFIT;
               end else begin
                  res_gs_in = pick_st_ff;
                  res_gl_in = len_ff;
                  if (pick_ln_ff == len_ff) begin
                     count_in   = cnt_less;
                     sh_up_in   = 1'b0;
                     sh_rd_in   = IW'(pick_ff + CNT_ONE);
                     sh_left_in = cnt_less - pick_ff;
                     sh_pend_in = (cnt_less != pick_ff);
                     if (mode_ff == flba_pkg::FIT_NEXT) begin
                        cursor_in = (pick_ff >= cnt_less) ? '0 : pick_ff[IW-1:0];
                     end
                     if (cnt_less != pick_ff) begin
                        state_in = ST_SHIFT;
                     end
                  end else begin
                     fw_pend_in = 1'b1;
                     fw_idx_in  = pick_ff[IW-1:0];
                     fw_st_in   = pick_st_ff + len_ff;
                     fw_ln_in   = pick_ln_ff - len_ff;
                     if (mode_ff == flba_pkg::FIT_NEXT) begin
                        cursor_in = pick_ff[IW-1:0];
                     end
                     state_in = ST_FIX;
                  end
               end
            end else begin
               priority if (pv && nv) begin
                  fw_pend_in = 1'b1;
                  fw_idx_in  = IW'(pick_ff - CNT_ONE);
                  fw_st_in   = prev_st_ff;
                  fw_ln_in   = prev_ln_ff + len_ff + next_ln_ff;
                  count_in   = cnt_less;
                  sh_up_in   = 1'b0;
                  sh_rd_in   = IW'(pick_ff + CNT_ONE);
                  sh_left_in = cnt_less - pick_ff;
                  sh_pend_in = (cnt_less != pick_ff);
                  state_in   = ST_FIX;
               end else if (pv) begin
                  fw_pend_in = 1'b1;
                  fw_idx_in  = IW'(pick_ff - CNT_ONE);
                  fw_st_in   = prev_st_ff;
                  fw_ln_in   = prev_ln_ff + len_ff;
                  state_in   = ST_FIX;
               end else if (nv) begin
                  fw_pend_in = 1'b1;
                  fw_idx_in  = pick_ff[IW-1:0];
                  fw_st_in   = s_ff;
                  fw_ln_in   = next_ln_ff + len_ff;
                  state_in   = ST_FIX;
               end else if (count_ff == CNT_FULL) begin
                  res_status_in = flba_pkg::STAT_FULL;
               end else begin
                  fw_pend_in = 1'b1;
                  fw_idx_in  = pick_ff[IW-1:0];
                  fw_st_in   = s_ff;
                  fw_ln_in   = len_ff;
                  count_in   = count_ff + CNT_ONE;
                  sh_up_in   = 1'b1;
                  sh_rd_in   = cnt_less[IW-1:0];
                  sh_left_in = count_ff - pick_ff;
                  sh_pend_in = (count_ff != pick_ff);
                  state_in   = (count_ff != pick_ff) ? ST_SHIFT : ST_FIX;
               end
            end
         end

         // single entry write
         ST_FIX: begin
            wr_en      = 1'b1;
            fw_pend_in = 1'b0;
            state_in   = sh_pend_ff ? ST_SHIFT : ST_DONE;
         end

         // move entries one place up or down, read ahead of write
         ST_SHIFT: begin
            rd_addr = sh_rd_ff;
            if (wr_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_idx_ff;
               wr_data = rdata_ff;
            end
            if (sh_left_ff != '0) begin
               wr_pend_in = 1'b1;
               wr_idx_in  = sh_up_ff ? sh_rd_ff + IW'(1) : sh_rd_ff - IW'(1);
               sh_rd_in   = sh_up_ff ? sh_rd_ff - IW'(1) : sh_rd_ff + IW'(1);
               sh_left_in = sh_left_ff - CNT_ONE;
            end else if (!wr_pend_ff) begin
               sh_pend_in = 1'b0;
               state_in   = fw_pend_ff ? ST_FIX : ST_DONE;
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_gs_in     = gs_wide[31:0];
               rsp_gl_in     = gl_wide[31:0];
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // state and registered outputs
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         base_ff      <= '0;
         hlen_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         chk_v_ff     <= 1'b0;
         fw_pend_ff   <= 1'b0;
         sh_pend_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         base_ff      <= base_in;
         hlen_ff      <= hlen_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         chk_v_ff     <= chk_v_in;
         fw_pend_ff   <= fw_pend_in;
         sh_pend_ff   <= sh_pend_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;  s_ff <= s_in;  len_ff <= len_in;
      rd_idx_ff <= rd_idx_in;  chk_idx_ff <= chk_idx_in;  n_iss_ff <= n_iss_in;
      hit_ff <= hit_in;  found_ff <= found_in;  pick_ff <= pick_in;
      pick_st_ff <= pick_st_in;  pick_ln_ff <= pick_ln_in;
      prev_v_ff <= prev_v_in;  prev_st_ff <= prev_st_in;  prev_ln_ff <= prev_ln_in;
      next_v_ff <= next_v_in;  next_st_ff <= next_st_in;  next_ln_ff <= next_ln_in;
      fw_idx_ff <= fw_idx_in;  fw_st_ff <= fw_st_in;  fw_ln_ff <= fw_ln_in;
      sh_up_ff <= sh_up_in;  sh_rd_ff <= sh_rd_in;  sh_left_ff <= sh_left_in;
      wr_idx_ff <= wr_idx_in;
      res_status_ff <= res_status_in;  res_gs_ff <= res_gs_in;  res_gl_ff <= res_gl_in;
      rsp_status_ff <= rsp_status_in;  rsp_gs_ff <= rsp_gs_in;  rsp_gl_ff <= rsp_gl_in;
   end

   // ---------------------------------------------------------------
   // free range table
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_q[rd_addr];
   end

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `FLBA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `FLBA_ASSERT_IMPLY(a_shift_no_clash, clock, reset,
      state_ff == ST_SHIFT && wr_pend_ff && sh_left_ff != '0, wr_idx_ff != sh_rd_ff)
   `FLBA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready,
      state_ff == ST_START)

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// Free list block allocator testbench
// Drives allocate, free, init and unknown requests through the valid/ready
// channels. Fit modes and heap registers change between phases. A scoreboard
// predicts each result from its own copy of the free table and checks every
// field of every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   logic [1:0]  status;
   logic [31:0] gstart;
   logic [31:0] glength;
} alloc_result_type;

class alloc_scoreboard;
   logic [31:0]      free_start [64];
   logic [31:0]      free_len [64];
   int               free_count;
   int               cursor;
   logic [1:0]       fit_mode;
   logic [31:0]      heap_base;
   logic [31:0]      heap_len;
   alloc_result_type expected_q[$];
   int               errors;

   function new();
      free_count = 0;
      cursor = 0;
      fit_mode = flba_pkg::FIT_FIRST;
      heap_base = 0;
      heap_len = 0;
      errors = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == flba_pkg::CSR_FIT_MODE) fit_mode = val[1:0];
      else if (idx == flba_pkg::CSR_HEAP_BASE) heap_base = val;
      else if (idx == flba_pkg::CSR_HEAP_LENGTH) heap_len = val;
   endfunction

   function void drop_entry(int idx);
      for (int k = idx; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k + 1];
         free_len[k] = free_len[k + 1];
      end
      free_count--;
   endfunction

   // Carve len from the low end of entry idx; drop it on an exact fit
   function logic [31:0] carve(int idx, logic [31:0] len);
      logic [31:0] s;
      s = free_start[idx];
      if (free_len[idx] == len) drop_entry(idx);
      else begin
         free_start[idx] = s + len;
         free_len[idx] = free_len[idx] - len;
      end
      return s;
   endfunction

   function bit allocate(logic [31:0] len, output logic [31:0] start);
      int  pick;
      int  k;
      int  base;
      bit  found;
      bit  exact;
      pick = 0;
      found = 0;
      start = 0;
      if (len == 0 || free_count == 0) return 0;
      if (fit_mode == flba_pkg::FIT_BEST) begin
         for (k = 0; k < free_count; k++) begin
            if (free_len[k] == len) begin
               pick = k;
               found = 1;
               break;
            end
            if (free_len[k] > len && (!found || free_len[k] < free_len[pick])) begin
               pick = k;
               found = 1;
            end
         end
         if (!found) return 0;
         start = carve(pick, len);
         return 1;
      end
      if (fit_mode == flba_pkg::FIT_NEXT) begin
         base = (cursor < free_count) ? cursor : 0;
         for (int n = 0; n < free_count; n++) begin
            k = base + n;
            if (k >= free_count) k -= free_count;
            if (free_len[k] >= len) begin
               exact = (free_len[k] == len);
               start = carve(k, len);
               cursor = (exact && k >= free_count) ? 0 : k;
               return 1;
            end
         end
         return 0;
      end
      for (k = 0; k < free_count; k++)
         if (free_len[k] >= len) begin
            start = carve(k, len);
            return 1;
         end
      return 0;
   endfunction

   // Insert in sorted place and merge with touching neighbors
   function logic [1:0] release_range(logic [31:0] s, logic [31:0] len);
      int          p;
      bit          prev;
      bit          nxt;
      logic [31:0] prev_end;
      logic [31:0] this_end;
      p = 0;
      if (len == 0) return flba_pkg::STAT_DONE;
      while (p < free_count && free_start[p] < s) p++;
      this_end = s + len;
      prev = 0;
      if (p > 0) begin
         prev_end = free_start[p - 1] + free_len[p - 1];
         prev = (prev_end == s);
      end
      nxt = (p < free_count) && (this_end == free_start[p]);
      if (prev && nxt) begin
         free_len[p - 1] = free_len[p - 1] + len + free_len[p];
         drop_entry(p);
      end else if (prev) begin
         free_len[p - 1] = free_len[p - 1] + len;
      end else if (nxt) begin
         free_start[p] = s;
         free_len[p] = free_len[p] + len;
      end else begin
         if (free_count >= 64) return flba_pkg::STAT_FULL;
         for (int k = free_count; k > p; k--) begin
            free_start[k] = free_start[k - 1];
            free_len[k] = free_len[k - 1];
         end
         free_start[p] = s;
         free_len[p] = len;
         free_count++;
      end
      return flba_pkg::STAT_DONE;
   endfunction

   // Note an accepted request and queue its expected result
   function alloc_result_type note_request(logic [1:0] func, logic [31:0] s,
                                           logic [31:0] len);
      alloc_result_type r;
      logic [31:0]      got;
      r.status = flba_pkg::STAT_DONE;
      r.gstart = 0;
      r.glength = 0;
      if (func == flba_pkg::FUNC_ALLOC) begin
         if (allocate(len, got)) begin
            r.gstart = got;
            r.glength = len;
         end else r.status = flba_pkg::STAT_NOFIT;
      end else if (func == flba_pkg::FUNC_FREE) begin
         r.status = release_range(s, len);
      end else if (func == flba_pkg::FUNC_INIT) begin
         cursor = 0;
         if (heap_len == 0) free_count = 0;
         else begin
            free_start[0] = heap_base;
            free_len[0] = heap_len;
            free_count = 1;
         end
      end
      expected_q.push_back(r);
      return r;
   endfunction

   function void check_result(logic [1:0] st, logic [31:0] gs, logic [31:0] gl);
      alloc_result_type e;
      if (expected_q.size() == 0) begin
         $error("result with no request outstanding: status %0d", st);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, st);
         errors++;
      end
      if (gs !== e.gstart) begin
         $error("granted_start: expected %h, actual %h", e.gstart, gs);
         errors++;
      end
      if (gl !== e.glength) begin
         $error("granted_length: expected %h, actual %h", e.glength, gl);
         errors++;
      end
   endfunction
endclass

module tb_top;

   typedef struct {
      logic [31:0] s;
      logic [31:0] l;
   } held_block_type;

   localparam int WATCHDOG_LIMIT = 5000;
   // function code with no defined operation
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_func = 0;
   logic [31:0] req_block_start = 0;
   logic [31:0] req_block_length = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_granted_start;
   logic [31:0] rsp_granted_length;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   alloc_scoreboard sb = new();
   held_block_type  held_q[$];
   bit              gaps_on = 1;
   bit              hold_rsp = 0;
   int              idle_cycles = 0;

   free_list_block_allocator DUT (.*);

   always #2 clock = ~clock;

   // Send one item; keep valid high afterwards unless a gap comes next time
   task automatic send_item(logic [1:0] func, logic [31:0] s, logic [31:0] len);
      alloc_result_type r;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_block_start <= s;
      req_block_length <= len;
      do @(posedge clock); while (!req_ready);
      r = sb.note_request(func, s, len);
      if (func == flba_pkg::FUNC_INIT) held_q.delete();
      else if (func == flba_pkg::FUNC_ALLOC && r.status == flba_pkg::STAT_DONE)
         held_q.push_back('{r.gstart, len});
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Write all three registers back to back while the block is idle
   task automatic write_regs(logic [1:0] mode, logic [31:0] base, logic [31:0] len);
      logic [31:0] vals [3];
      vals = '{{30'd0, mode}, base, len};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(i[1:0], vals[i]);
      end
      csr_valid <= 0;
   endtask

   // Mostly well-formed traffic: allocations and frees of held blocks
   task automatic random_item();
      int             sel;
      int             idx;
      logic [31:0]    part;
      held_block_type b;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         if ($urandom_range(0, 19) == 0)
            send_item(flba_pkg::FUNC_ALLOC, $urandom, $urandom);
         else if ($urandom_range(0, 29) == 0)
            send_item(flba_pkg::FUNC_ALLOC, $urandom, 0);
         else send_item(flba_pkg::FUNC_ALLOC, $urandom, $urandom_range(1, 48));
      end else if (sel < 88 && held_q.size() != 0) begin
         idx = $urandom_range(0, held_q.size() - 1);
         b = held_q[idx];
         if (b.l > 1 && $urandom_range(0, 2) == 0) begin
            part = $urandom_range(1, b.l - 1);
            held_q[idx] = '{b.s + part, b.l - part};
            send_item(flba_pkg::FUNC_FREE, b.s, part);
         end else begin
            held_q.delete(idx);
            send_item(flba_pkg::FUNC_FREE, b.s, b.l);
         end
      end else if (sel < 93) begin
         send_item(flba_pkg::FUNC_FREE, $urandom, $urandom_range(0, 1) ? $urandom : 0);
      end else if (sel < 96) begin
         send_item(flba_pkg::FUNC_INIT, $urandom, $urandom);
      end else begin
         send_item(FUNC_UNKNOWN, $urandom, $urandom);
      end
   endtask

   // Result side: check each item, stall in random bursts or a long hold
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_granted_start, rsp_granted_length);
         if (hold_rsp) begin
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Long receiver hold-off counted here while the sender keeps offering
   task automatic long_hold();
      @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
   endtask

   // Watchdog on cycles with no accepted item on any channel
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else if (!reset) idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] base;
      logic [31:0] hlen;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty table, zero lengths, exact fits, merges, wrap
      send_item(flba_pkg::FUNC_ALLOC, 0, 1);
      send_item(flba_pkg::FUNC_FREE, 32'h10, 0);
      send_item(flba_pkg::FUNC_INIT, 0, 0);
      drain();
      write_regs(flba_pkg::FIT_FIRST, 32'h1000, 32'h100);
      send_item(flba_pkg::FUNC_INIT, 0, 0);
      send_item(flba_pkg::FUNC_ALLOC, 0, 0);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'hFFFF_FFFF);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'h10);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'h10);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'h10);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'hD0);
      send_item(flba_pkg::FUNC_ALLOC, 0, 1);
      send_item(flba_pkg::FUNC_FREE, 32'h1000, 32'h10);
      send_item(flba_pkg::FUNC_FREE, 32'h1020, 32'h10);
      send_item(flba_pkg::FUNC_FREE, 32'h1010, 32'h10);
      send_item(FUNC_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(flba_pkg::FUNC_FREE, 32'hFFFF_FFF0, 32'h10);
      send_item(flba_pkg::FUNC_FREE, 0, 32'h8);
      send_item(flba_pkg::FUNC_FREE, 32'h1030, 32'hFFFF_EFC0);
      drain();
      write_regs(flba_pkg::FIT_BEST, 0, 32'hFFFF_FFFF);
      send_item(flba_pkg::FUNC_INIT, 0, 0);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'hFFFF_FFFF);
      send_item(flba_pkg::FUNC_FREE, 32'h100, 32'h100);
      send_item(flba_pkg::FUNC_FREE, 32'h300, 32'h10);
      send_item(flba_pkg::FUNC_ALLOC, 0, 32'h10);
      drain();

      // Phases over fit modes and heap settings
      for (int ph = 0; ph < 12; ph++) begin
         gaps_on = (ph < 10);
         case (ph % 4)
            0: base = 0;
            1: base = 32'hFFFF_FF00;
            2: base = $urandom;
            default: base = 32'h7FFF_FFF0;
         endcase
         if (ph == 4) hlen = 32'hFFFF_FFFF;
         else if (ph == 5 || ph == 9) hlen = 0;
         else hlen = $urandom_range(64, 4096);
         write_regs(2'(ph % 3), base, hlen);
         send_item(flba_pkg::FUNC_INIT, $urandom, $urandom);
         if (hlen == 0) begin
            // Fragment the table until it fills and rejects a free
            for (int k = 0; k < 70; k++) begin
               send_item(flba_pkg::FUNC_FREE, base + 4 * k, $urandom_range(1, 2));
               if (k < 64) held_q.push_back('{base + 4 * k, 1});
            end
         end
         if (ph == 3) begin
            fork
               long_hold();
               for (int n = 0; n < 130; n++) random_item();
            join
         end else begin
            for (int n = 0; n < 130; n++) random_item();
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/flba_pkg.sv
hdl/free_list_block_allocator.sv
dv/tb_top.sv
